[sv/lsfd_pkg.sv]
// Shared types, constants and the salt table for the salted feedback stream decryptor.
// No dependencies; imported by every module of the block.
package lsfd_pkg;

	// Register indexes of the configuration port.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_INIT_LCG   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INIT_KEY   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INIT_PHASE = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INIT_PREV  = 2'd3;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned PHASE_W    = 3;

	// Reset values of the configuration registers.
	localparam logic [WORD_W-1:0]  RST_INIT_LCG   = 32'h0000_4816;
	localparam logic [WORD_W-1:0]  RST_INIT_KEY   = 32'h0000_0000;
	localparam logic [PHASE_W-1:0] RST_INIT_PHASE = 3'd1;
	localparam logic [BYTE_W-1:0]  RST_INIT_PREV  = 8'hE9;

	// Generator constants.
	localparam logic [WORD_W-1:0]  LCG_MUL      = 32'h41C6_4E6D;
	localparam logic [WORD_W-1:0]  LCG_ADD      = 32'h0000_3039;
	localparam logic [PHASE_W-1:0] PHASE_RELOAD = 3'd4;

	// Stream payload widths.
	localparam int unsigned S_TDATA_W = 8;
	localparam int unsigned M_TDATA_W = 16;

	// Values loaded into the running state on restart.
	typedef struct packed {
		logic [WORD_W-1:0]  init_lcg;
		logic [WORD_W-1:0]  init_key;
		logic [PHASE_W-1:0] init_phase;
		logic [BYTE_W-1:0]  init_prev;
	} cfg_t;

	// One request held in the input register.
	typedef struct packed {
		logic [BYTE_W-1:0] cipher_byte;
		logic              restart;
		logic              last;
	} in_req_t;

	// One result held in the output register.
	typedef struct packed {
		logic [BYTE_W-1:0]  plain_byte;
		logic [PHASE_W-1:0] phase_count;
		logic               last;
	} out_req_t;

	// Salt table: 64 words read as little-endian bytes.
	localparam logic [WORD_W-1:0] SALT_WORDS [64] = '{
		32'h7638D244, 32'h8DDFDA30, 32'hA6954CAC, 32'hC1E302AF, 32'h1D2968DD,
		32'h8807F899, 32'h569A6F63, 32'h7103C6EE, 32'hE1DC78CA, 32'h64B4BE83,
		32'h2B690A0E, 32'hC9DB4FFC, 32'hA734F4EA, 32'h87C59EBF, 32'hB10B2CD4,
		32'h31554041, 32'hF9D8A473, 32'h96E211A8, 32'h664D1AD3, 32'h89E0C2A5,
		32'h2DA1BD4A, 32'hEFFB79EC, 32'hDEC35CAD, 32'hE60CB660, 32'h7CCBCEBB,
		32'hF54E1400, 32'h6A51D18B, 32'hFED7FA74, 32'h82265AF7, 32'h7E46359C,
		32'h59AE5325, 32'h9FB93C21, 32'h9B7B6201, 32'h5E8E4B10, 32'h5FC87D94,
		32'hA997CFD0, 32'h671B392F, 32'h19F25B2A, 32'hB32E3308, 32'h619DF348,
		32'h5847A36C, 32'hBA9128EB, 32'h15CD801E, 32'h8F320F17, 32'h425D7ACC,
		32'h50433EE9, 32'hABE4E892, 32'h36ED6B45, 32'h1C7237B7, 32'h8C84F6C7,
		32'h65FF816D, 32'h0D13F0D9, 32'hC4FD5722, 32'hC03D52B5, 32'h3A7785D6,
		32'h75232093, 32'h160449A2, 32'h987FB286, 32'h1854E5BC, 32'h06E7D527,
		32'hAA70B03F, 32'h1F056E8A, 32'hF190B824, 32'h093BA012
	};

	// Byte lookup: the upper six index bits pick the word, the lower two the byte lane.
	function automatic logic [BYTE_W-1:0] salt_byte(input logic [BYTE_W-1:0] idx);
		logic [WORD_W-1:0] w;
		w = SALT_WORDS[idx[7:2]];
		case (idx[1:0])
			2'd0: salt_byte = w[7:0];
			2'd1: salt_byte = w[15:8];
			2'd2: salt_byte = w[23:16];
			default: salt_byte = w[31:24];
		endcase
	endfunction

endpackage

[sv/lsfd_cfg_regs.sv]
// Configuration register file: the four restart values of the decryptor.
// Depends on lsfd_pkg for the register indexes, widths and reset values.
module lsfd_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lsfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lsfd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output lsfd_pkg::cfg_t                     cfg
);
	import lsfd_pkg::*;

	cfg_t cfg_q;

	// Each register takes the low bits of the write data, as many as it is wide.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_lcg   <= RST_INIT_LCG;
			cfg_q.init_key   <= RST_INIT_KEY;
			cfg_q.init_phase <= RST_INIT_PHASE;
			cfg_q.init_prev  <= RST_INIT_PREV;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INIT_LCG:   cfg_q.init_lcg   <= cfg_data[WORD_W-1:0];
				REG_INIT_KEY:   cfg_q.init_key   <= cfg_data[WORD_W-1:0];
				REG_INIT_PHASE: cfg_q.init_phase <= cfg_data[PHASE_W-1:0];
				REG_INIT_PREV:  cfg_q.init_prev  <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/lsfd_core.sv]
// Keystream state and per-byte decryption: phase counter, generator, key word, chaining byte.
// Depends on lsfd_pkg for the types, generator constants and the salt table.
module lsfd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsfd_pkg::cfg_t       cfg,
	input  logic                 step,
	input  lsfd_pkg::in_req_t    req,
	output lsfd_pkg::out_req_t   res
);
	import lsfd_pkg::*;

	logic [WORD_W-1:0]  lcg_q, key_q;
	logic [PHASE_W-1:0] phase_q;
	logic [BYTE_W-1:0]  prev_q;

	logic [WORD_W-1:0]  lcg_base, key_base, lcg_next, key_next;
	logic [PHASE_W-1:0] phase_base, phase_dec, phase_next;
	logic [BYTE_W-1:0]  prev_base;

	// A restart request starts from the configured values instead of the running state.
	always_comb begin
		lcg_base   = req.restart ? cfg.init_lcg   : lcg_q;
		key_base   = req.restart ? cfg.init_key   : key_q;
		phase_base = req.restart ? cfg.init_phase : phase_q;
		prev_base  = req.restart ? cfg.init_prev  : prev_q;
	end

	// Count down; at zero reload and step the generator, otherwise use the next key byte.
	always_comb begin
		phase_dec = phase_base - PHASE_W'(1);
		if (phase_dec == '0) begin
			phase_next = PHASE_RELOAD;
			lcg_next   = WORD_W'(lcg_base * LCG_MUL) + LCG_ADD;
			key_next   = lcg_next;
		end else begin
			phase_next = phase_dec;
			lcg_next   = lcg_base;
			key_next   = key_base >> BYTE_W;
		end
	end

	// Result of the current request.
	always_comb begin
		res.plain_byte  = salt_byte(req.cipher_byte ^ prev_base) ^ key_next[BYTE_W-1:0];
		res.phase_count = phase_next;
		res.last        = req.last;
	end

	// State advances once for each request that moves on to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q   <= RST_INIT_LCG;
			key_q   <= RST_INIT_KEY;
			phase_q <= RST_INIT_PHASE;
			prev_q  <= RST_INIT_PREV;
		end else if (step) begin
			lcg_q   <= lcg_next;
			key_q   <= key_next;
			phase_q <= phase_next;
			prev_q  <= req.cipher_byte;
		end
	end

endmodule

[sv/lcg_salted_feedback_stream_decrypt.sv]
// Salted feedback stream decryptor, top level: input register, decrypt core, output register.
// Depends on lsfd_pkg, lsfd_cfg_regs and lsfd_core.
//
// Usage:
//   The slave stream carries one encrypted byte per request in s_tdata; s_tuser is the
//   restart flag, which reloads all keystream state from the configuration registers
//   before the byte is processed; s_tlast marks the end of a buffer and is copied to m_tlast.
//   The master stream returns the plain byte and the phase counter after that byte.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data while the
//   stream is idle; they act on the state only at reset or on a restart request.
// Pipeline and throughput:
//   A request is captured in the input register, passes the combinational core and is
//   captured in the output register, which drives the master side. One request is taken
//   every cycle while m_tready keeps the output register draining; the limiting path is
//   the generator step (one 32-bit constant multiply and add) feeding the state registers.
// Reset and stalls:
//   arst_n clears the valid flags of both stream registers and loads the reset values
//   into the configuration registers and the running state. When m_tready is low, the
//   output register holds its result and the input register still takes one more request;
//   s_tready falls only when both are full.
module lcg_salted_feedback_stream_decrypt (
	input  logic                               clk,
	input  logic                               arst_n,
	// Slave stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lsfd_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] cipher_byte
	input  logic [0:0]                         s_tuser,  // [0] restart
	input  logic                               s_tlast,
	// Master stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lsfd_pkg::M_TDATA_W-1:0]     m_tdata,  // [7:0] plain_byte, [10:8] phase_count
	output logic                               m_tlast,
	// Configuration write port
	input  logic                               cfg_we,
	input  logic [lsfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lsfd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lsfd_pkg::*;

	cfg_t     cfg;
	in_req_t  req_s1;
	logic     valid_s1;
	out_req_t res_comb;
	out_req_t res_s2;
	logic     valid_s2;
	logic     advance;

	lsfd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage one moves on when the output register is empty or being drained.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.cipher_byte <= s_tdata[BYTE_W-1:0];
			req_s1.restart     <= s_tuser[0];
			req_s1.last        <= s_tlast;
		end
	end

	lsfd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.req    (req_s1),
		.res    (res_comb)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(M_TDATA_W - BYTE_W - PHASE_W){1'b0}}, res_s2.phase_count,
		res_s2.plain_byte};
	assign m_tlast  = res_s2.last;

endmodule

[sim/tb_lcg_salted_feedback_stream_decrypt.sv]
// Self-checking testbench for the salted feedback stream decryptor.
// Depends on lsfd_pkg and lcg_salted_feedback_stream_decrypt; a local predictor
// computes every plain byte, and a checker process compares it with the master stream.
`timescale 1ns / 100ps

module tb_lcg_salted_feedback_stream_decrypt;

	import lsfd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic [0:0]             s_tuser;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	lcg_salted_feedback_stream_decrypt dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Registers as the predictor sees them.
	logic [WORD_W-1:0]  shadow_init_lcg;
	logic [WORD_W-1:0]  shadow_init_key;
	logic [PHASE_W-1:0] shadow_init_phase;
	logic [BYTE_W-1:0]  shadow_init_prev;

	// Running keystream state of the predictor.
	logic [WORD_W-1:0]  gen_state;
	logic [WORD_W-1:0]  key_stream;
	logic [PHASE_W-1:0] phase_left;
	logic [BYTE_W-1:0]  chain_byte;

	out_req_t plain_due[$];

	int unsigned fail_count;
	int unsigned cycle_count;
	bit          tx_no_gap;
	bit          rx_no_stall;
	int unsigned rx_hold_cycles;

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Steps the predicted keystream by one byte and returns the expected result.
	task automatic decrypt_predict(input logic [BYTE_W-1:0] cb, input logic restart,
			input logic last, output out_req_t res);
		logic [WORD_W-1:0] salt_word;
		logic [BYTE_W-1:0] salt_val;
		logic [BYTE_W-1:0] idx;
		if (restart) begin
			gen_state  = shadow_init_lcg;
			key_stream = shadow_init_key;
			phase_left = shadow_init_phase;
			chain_byte = shadow_init_prev;
		end
		// A phase of zero wraps to seven, so only a true zero after the decrement steps.
		phase_left = phase_left - PHASE_W'(1);
		if (phase_left != '0) begin
			key_stream = key_stream >> 8;
		end else begin
			phase_left = PHASE_RELOAD;
			gen_state  = gen_state * LCG_MUL + LCG_ADD;
			key_stream = gen_state;
		end
		idx       = cb ^ chain_byte;
		salt_word = SALT_WORDS[idx[7:2]];
		salt_val  = 8'(salt_word >> (8 * idx[1:0]));
		res.plain_byte  = salt_val ^ key_stream[7:0];
		res.phase_count = phase_left;
		res.last        = last;
		chain_byte = cb;
	endtask

	// Blocks until every predicted result has been taken from the master side.
	task automatic wait_drained();
		while (plain_due.size() != 0)
			@(posedge clk);
	endtask

	// Writes one register once the stream is idle and mirrors it in the predictor.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_INIT_LCG:   shadow_init_lcg   = val;
			REG_INIT_KEY:   shadow_init_key   = val;
			REG_INIT_PHASE: shadow_init_phase = val[PHASE_W-1:0];
			REG_INIT_PREV:  shadow_init_prev  = val[BYTE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all_regs(input logic [WORD_W-1:0] lcg, input logic [WORD_W-1:0] key,
			input logic [CFG_DATA_W-1:0] ph, input logic [CFG_DATA_W-1:0] prev);
		write_reg(REG_INIT_LCG, lcg);
		write_reg(REG_INIT_KEY, key);
		write_reg(REG_INIT_PHASE, ph);
		write_reg(REG_INIT_PREV, prev);
	endtask

	// Offers one byte after a random gap and records its expected result on acceptance.
	task automatic send_byte(input logic [BYTE_W-1:0] cb, input logic restart, input logic last);
		int unsigned gap;
		out_req_t    res;
		gap = tx_no_gap ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid   <= 1'b1;
		s_tdata    <= cb;
		s_tuser[0] <= restart;
		s_tlast    <= last;
		do
			@(posedge clk);
		while (!s_tready);
		decrypt_predict(cb, restart, last, res);
		plain_due.push_back(res);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// Receiver: random stalls, an optional long hold-off, and a check of every result.
	initial begin
		int unsigned stall;
		out_req_t    exp_res;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_no_stall ? 0 : $urandom_range(0, 3);
			if (rx_hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			if (plain_due.size() == 0) begin
				$error("result %0h arrived with no request outstanding", m_tdata);
				fail_count++;
			end else begin
				exp_res = plain_due.pop_front();
				check_field("plain_byte", 32'(exp_res.plain_byte), 32'(m_tdata[7:0]));
				check_field("phase_count", 32'(exp_res.phase_count), 32'(m_tdata[10:8]));
				check_field("tdata_pad", 32'd0, 32'(m_tdata[M_TDATA_W-1:11]));
				check_field("last_out", 32'(exp_res.last), 32'(m_tlast));
			end
		end
	end

	// Reset values: the first byte steps the generator since the phase starts at one.
	task automatic test_reset_defaults();
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h5A, 1'b0, 1'b1);
		send_byte(8'hE9, 1'b1, 1'b0);
		send_byte(8'hA5, 1'b0, 1'b1);
		stop_sending();
	endtask

	// Smallest and largest register values, with the phase at one and at four, each loaded by a restart.
	task automatic test_config_extremes();
		write_all_regs(32'h0000_0000, 32'h0000_0000, 32'd1, 32'd0);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b1);
		stop_sending();
		write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4, 32'hFFFF_FFFF);
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b1);
		stop_sending();
	endtask

	// Phase loaded outside one to four: zero wraps to seven, larger values count down.
	task automatic test_phase_out_of_range();
		write_reg(REG_INIT_PHASE, 32'd0);
		send_byte(8'h3C, 1'b1, 1'b0);
		send_byte(8'hC3, 1'b0, 1'b0);
		stop_sending();
		write_reg(REG_INIT_PHASE, 32'd7);
		send_byte(8'h11, 1'b1, 1'b0);
		send_byte(8'h22, 1'b0, 1'b1);
		stop_sending();
		write_reg(REG_INIT_PHASE, 32'hFFFF_FFF5);
		send_byte(8'h44, 1'b1, 1'b0);
		stop_sending();
	endtask

	// A register write changes nothing until the next restart.
	task automatic test_register_reload();
		write_all_regs(32'h1234_5678, 32'h9ABC_DEF0, 32'd3, 32'h0000_0077);
		send_byte(8'h10, 1'b0, 1'b0);
		send_byte(8'h20, 1'b0, 1'b0);
		send_byte(8'h30, 1'b1, 1'b1);
		stop_sending();
	endtask

	// The receiver holds off while bytes keep coming, so the block fills and stalls.
	task automatic test_backpressure();
		tx_no_gap = 1'b1;
		rx_hold_cycles = 40;
		for (int i = 0; i < 24; i++)
			send_byte(8'($urandom_range(0, 255)), i == 0, (i % 8) == 7);
		stop_sending();
		wait_drained();
		tx_no_gap = 1'b0;
	endtask

	// The sender pauses until every result is back, then resumes the same buffer.
	task automatic test_sender_pause();
		for (int i = 0; i < 10; i++)
			send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		stop_sending();
		wait_drained();
		for (int i = 0; i < 10; i++)
			send_byte(8'($urandom_range(0, 255)), 1'b0, i == 9);
		stop_sending();
	endtask

	// Random bytes over several register settings; one setting runs without idling.
	task automatic test_random_stream();
		logic [CFG_DATA_W-1:0] ph;
		for (int set = 0; set < 6; set++) begin
			wait_drained();
			if (set == 0) begin
				write_all_regs(32'h0000_0000, 32'h0000_0000, 32'd1, 32'd0);
			end else if (set == 1) begin
				write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4, 32'd255);
			end else begin
				ph = $urandom();
				if ($urandom_range(0, 3) != 0)
					ph[PHASE_W-1:0] = PHASE_W'($urandom_range(1, 4));
				write_all_regs($urandom(), $urandom(), ph, $urandom());
			end
			tx_no_gap   = (set == 2);
			rx_no_stall = (set == 2);
			for (int i = 0; i < 250; i++)
				send_byte(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 49) == 0,
					$urandom_range(0, 15) == 0);
			stop_sending();
		end
		tx_no_gap   = 1'b0;
		rx_no_stall = 1'b0;
	endtask

	// Main sequence: reset, directed tests, random stream, drain and verdict.
	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		s_tlast        = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		fail_count     = 0;
		tx_no_gap      = 1'b0;
		rx_no_stall    = 1'b0;
		rx_hold_cycles = 0;

		shadow_init_lcg   = RST_INIT_LCG;
		shadow_init_key   = RST_INIT_KEY;
		shadow_init_phase = RST_INIT_PHASE;
		shadow_init_prev  = RST_INIT_PREV;
		gen_state  = RST_INIT_LCG;
		key_stream = RST_INIT_KEY;
		phase_left = RST_INIT_PHASE;
		chain_byte = RST_INIT_PREV;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_config_extremes();
		test_phase_out_of_range();
		test_register_reload();
		test_backpressure();
		test_sender_pause();
		test_random_stream();

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
